[sv/color_key_sprite_blitter_assert.svh]
// assertion macros for the color-key sprite blitter
// used by the top level; expects clk and rst_n in scope
`ifndef COLOR_KEY_SPRITE_BLITTER_ASSERT_SVH
`define COLOR_KEY_SPRITE_BLITTER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CKB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CKB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ckb_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the color-key sprite blitter
// no dependencies
package ckb_pkg;

    localparam int unsigned MAX_RESOLUTION_DEF = 2048;
    localparam int unsigned QUEUE_DEPTH_DEF    = 4;
    localparam int unsigned CMP_W              = 13;

    localparam logic [7:0]  KEY_TRANSPARENT = 8'd255;
    localparam logic [11:0] COL_LIMIT       = 12'd2048;
    localparam logic [2:0]  BPP_MAX         = 3'd4;

    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH    = 3'd0,
        REG_SCREEN_HEIGHT   = 3'd1,
        REG_BYTES_PER_PIXEL = 3'd2,
        REG_ORIGIN_X        = 3'd3,
        REG_ORIGIN_Y        = 3'd4,
        REG_SPRITE_WIDTH    = 3'd5,
        REG_COLOR_MODE      = 3'd6,
        REG_SOLID_COLOR     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [11:0] screen_width;
        logic [11:0] screen_height;
        logic [2:0]  bytes_per_pixel;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [11:0] sprite_width;
        logic        color_mode;
        logic [31:0] solid_color;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        screen_width:    12'd1024,
        screen_height:   12'd768,
        bytes_per_pixel: 3'd1,
        origin_x:        16'd0,
        origin_y:        16'd0,
        sprite_width:    12'd1,
        color_mode:      1'b0,
        solid_color:     32'd0
    };

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[sv/ckb_ifs.sv]
`timescale 1ns / 1ps
// channel interfaces: pixel input, store output, register writes
// no dependencies
interface ckb_pix_if;
    logic       valid;
    logic       ready;
    logic       start_of_sprite;
    logic [7:0] source_pixel;
    modport source (output valid, start_of_sprite, source_pixel, input ready);
    modport sink (input valid, start_of_sprite, source_pixel, output ready);
endinterface

interface ckb_store_if;
    logic        valid;
    logic        ready;
    logic [23:0] byte_address;
    logic [31:0] pixel_data;
    logic [2:0]  byte_count;
    modport source (output valid, byte_address, pixel_data, byte_count, input ready);
    modport sink (input valid, byte_address, pixel_data, byte_count, output ready);
endinterface

interface ckb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[sv/color_key_sprite_blitter.sv]
`timescale 1ns / 1ps
// top level of the color-key sprite blitter: register file, front, queue, back
// depends on ckb_pkg, ckb_ifs, ckb_front, ckb_queue, ckb_back and the assert header
//
//  port   role    carries
//  pix    sink    start_of_sprite, source_pixel
//  store  source  byte_address, pixel_data, byte_count
//  cfg    sink    index, data (register writes, always ready)
//
// one pixel per cycle is taken while the queue has room
// an opaque on-screen pixel passes the queue, multiply stage and output register
// the multiply stage and output register hold on a stalled store channel
// reset clears counters, queue and pipeline valids and loads default registers
`include "color_key_sprite_blitter_assert.svh"

module color_key_sprite_blitter #(
    parameter int unsigned MAX_RESOLUTION = ckb_pkg::MAX_RESOLUTION_DEF,
    parameter int unsigned QUEUE_DEPTH    = ckb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ckb_pix_if.sink   pix,
    ckb_store_if.source store,
    ckb_cfg_if.sink   cfg
);

    localparam int unsigned RES_W = $clog2(MAX_RESOLUTION + 1);
    localparam int unsigned QW    = 2 * RES_W + 32;

    ckb_pkg::cfg_t      cfg_reg, cfg_next;
    ckb_pkg::q_status_t q_status;
    logic [RES_W-1:0]   sw_eff, sh_eff;
    logic [11:0]        spw_eff;
    logic [2:0]         bpp_eff;
    logic               push, pop;
    logic [QW-1:0]      push_data, pop_data;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (ckb_pkg::cfg_idx_t'(cfg.index))
                ckb_pkg::REG_SCREEN_WIDTH:    cfg_next.screen_width    = cfg.data[11:0];
                ckb_pkg::REG_SCREEN_HEIGHT:   cfg_next.screen_height   = cfg.data[11:0];
                ckb_pkg::REG_BYTES_PER_PIXEL: cfg_next.bytes_per_pixel = cfg.data[2:0];
                ckb_pkg::REG_ORIGIN_X:        cfg_next.origin_x        = cfg.data[15:0];
                ckb_pkg::REG_ORIGIN_Y:        cfg_next.origin_y        = cfg.data[15:0];
                ckb_pkg::REG_SPRITE_WIDTH:    cfg_next.sprite_width    = cfg.data[11:0];
                ckb_pkg::REG_COLOR_MODE:      cfg_next.color_mode      = cfg.data[0];
                ckb_pkg::REG_SOLID_COLOR:     cfg_next.solid_color     = cfg.data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= ckb_pkg::CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    // effective settings after saturation
    always_comb
    begin
        sw_eff = (ckb_pkg::CMP_W'(cfg_reg.screen_width) > ckb_pkg::CMP_W'(MAX_RESOLUTION))
                 ? RES_W'(MAX_RESOLUTION) : RES_W'(cfg_reg.screen_width);
        sh_eff = (ckb_pkg::CMP_W'(cfg_reg.screen_height) > ckb_pkg::CMP_W'(MAX_RESOLUTION))
                 ? RES_W'(MAX_RESOLUTION) : RES_W'(cfg_reg.screen_height);
        if (cfg_reg.sprite_width == 12'd0)
            spw_eff = 12'd1;
        else if (cfg_reg.sprite_width > ckb_pkg::COL_LIMIT)
            spw_eff = ckb_pkg::COL_LIMIT;
        else
            spw_eff = cfg_reg.sprite_width;
        if (cfg_reg.bytes_per_pixel == 3'd0)
            bpp_eff = 3'd1;
        else if (cfg_reg.bytes_per_pixel > ckb_pkg::BPP_MAX)
            bpp_eff = ckb_pkg::BPP_MAX;
        else
            bpp_eff = cfg_reg.bytes_per_pixel;
    end

    ckb_front #(
        .RES_W (RES_W)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (pix.valid),
        .in_ready        (pix.ready),
        .start_of_sprite (pix.start_of_sprite),
        .source_pixel    (pix.source_pixel),
        .sw_eff          (sw_eff),
        .sh_eff          (sh_eff),
        .spw_eff         (spw_eff),
        .origin_x        (cfg_reg.origin_x),
        .origin_y        (cfg_reg.origin_y),
        .color_mode      (cfg_reg.color_mode),
        .solid_color     (cfg_reg.solid_color),
        .q_status        (q_status),
        .push            (push),
        .push_data       (push_data)
    );

    ckb_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    ckb_back #(
        .RES_W (RES_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .pop_data     (pop_data),
        .pop          (pop),
        .sw_eff       (sw_eff),
        .bpp_eff      (bpp_eff),
        .out_valid    (store.valid),
        .out_ready    (store.ready),
        .byte_address (store.byte_address),
        .pixel_data   (store.pixel_data),
        .byte_count   (store.byte_count)
    );

    `CKB_ASSERT_NOW(a_no_overflow, q_status.full, !pix.ready && !push, "queue overflow")
    `CKB_ASSERT_NOW(a_no_underflow, q_status.empty, !pop, "queue underflow")
    `CKB_ASSERT_NOW(a_key_dropped,
        pix.valid && pix.ready && (pix.source_pixel == ckb_pkg::KEY_TRANSPARENT),
        !push, "transparent pixel queued")
    `CKB_ASSERT_NOW(a_count_range, store.valid,
        (store.byte_count != 3'd0) && (store.byte_count <= ckb_pkg::BPP_MAX),
        "byte count out of range")

endmodule

[sv/ckb_front.sv]
`timescale 1ns / 1ps
// front end: sprite position counters, color-key test and clipping
// depends on ckb_pkg; pushes opaque on-screen pixels into the queue
module ckb_front #(
    parameter int unsigned RES_W = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   start_of_sprite,
    input  logic [7:0]             source_pixel,
    input  logic [RES_W-1:0]       sw_eff,
    input  logic [RES_W-1:0]       sh_eff,
    input  logic [11:0]            spw_eff,
    input  logic [15:0]            origin_x,
    input  logic [15:0]            origin_y,
    input  logic                   color_mode,
    input  logic [31:0]            solid_color,
    input  ckb_pkg::q_status_t     q_status,
    output logic                   push,
    output logic [2*RES_W+31:0]    push_data
);

    logic [10:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [10:0] col_eff;
    logic [15:0] row_eff;
    logic [11:0] col_inc;
    logic [15:0] x, y;
    logic        accept, keep;
    logic [31:0] data;

    always_comb
    begin
        in_ready = !q_status.full;
        accept   = in_valid && in_ready;
        col_eff  = start_of_sprite ? 11'd0 : col_reg;
        row_eff  = start_of_sprite ? 16'd0 : row_reg;
        x        = origin_x + {5'd0, col_eff};
        y        = origin_y + row_eff;
        keep     = (source_pixel != ckb_pkg::KEY_TRANSPARENT)
                   && (x < 16'(sw_eff)) && (y < 16'(sh_eff));
        data     = color_mode ? solid_color : {24'd0, source_pixel};
        push     = accept && keep;
        push_data = {RES_W'(x), RES_W'(y), data};
        col_inc  = {1'b0, col_eff} + 12'd1;
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_inc >= spw_eff)
            begin
                col_next = 11'd0;
                row_next = row_eff + 16'd1;
            end
            else
            begin
                col_next = col_inc[10:0];
                row_next = row_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= 11'd0;
            row_reg <= 16'd0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

[sv/ckb_queue.sv]
`timescale 1ns / 1ps
// short fifo between front and back ends
// depends on ckb_pkg for the status struct
module ckb_queue #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    push_data,
    input  logic                pop,
    output logic [WIDTH-1:0]    pop_data,
    output ckb_pkg::q_status_t  status
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        status.full  = (count_reg == CW'(DEPTH));
        status.empty = (count_reg == '0);
        pop_data     = mem_reg[rd_ptr_reg];
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        count_next   = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[sv/ckb_back.sv]
`timescale 1ns / 1ps
// back end: two-stage address pipeline (a multiply stage and the output register)
// depends on ckb_pkg; pops entries from the queue
module ckb_back #(
    parameter int unsigned RES_W = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ckb_pkg::q_status_t     q_status,
    input  logic [2*RES_W+31:0]    pop_data,
    output logic                   pop,
    input  logic [RES_W-1:0]       sw_eff,
    input  logic [2:0]             bpp_eff,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [23:0]            byte_address,
    output logic [31:0]            pixel_data,
    output logic [2:0]             byte_count
);

    localparam int unsigned PW = 2 * RES_W;
    localparam int unsigned LW = PW + 1;
    localparam int unsigned AW = LW + 2;

    logic             s1_valid_reg, s1_valid_next;
    logic [PW-1:0]    prod_reg;
    logic [RES_W-1:0] x1_reg;
    logic [31:0]      data1_reg;
    logic             out_valid_reg, out_valid_next;
    logic [23:0]      addr_reg;
    logic [31:0]      data_reg;
    logic [2:0]       count_reg;
    logic [RES_W-1:0] q_x, q_y;
    logic [31:0]      q_data;
    logic [LW-1:0]    lin;
    logic [AW-1:0]    addr_full;
    logic             adv1, adv2;

    always_comb
    begin
        q_x       = pop_data[2*RES_W+31 -: RES_W];
        q_y       = pop_data[RES_W+31 -: RES_W];
        q_data    = pop_data[31:0];
        adv2      = !out_valid_reg || out_ready;
        adv1      = !s1_valid_reg || adv2;
        pop       = adv1 && !q_status.empty;
        s1_valid_next  = adv1 ? !q_status.empty : s1_valid_reg;
        out_valid_next = adv2 ? s1_valid_reg : out_valid_reg;
        lin       = LW'(prod_reg) + LW'(x1_reg);
        addr_full = AW'(lin) * AW'(bpp_eff);
        out_valid    = out_valid_reg;
        byte_address = addr_reg;
        pixel_data   = data_reg;
        byte_count   = count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prod_reg  <= q_y * sw_eff;
            x1_reg    <= q_x;
            data1_reg <= q_data;
        end
        if (adv2 && s1_valid_reg)
        begin
            addr_reg  <= 24'(addr_full);
            data_reg  <= data1_reg;
            count_reg <= bpp_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
